[hdl/jsu_pkg.sv]
// types, codes and helper functions for the json string unescaper
// used by jsu_decode, jsu_out and json_string_unescape_utf8_core
package jsu_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CodeW    = 16;
  localparam int unsigned MaxRes   = 3;
  localparam int unsigned CntW     = 2;
  localparam int unsigned UserW    = 4;

  // character codes the parser looks at
  localparam logic [ByteW-1:0] ChQuote  = 8'h22;
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;
  localparam logic [ByteW-1:0] ChSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChLowB   = 8'h62;
  localparam logic [ByteW-1:0] ChLowF   = 8'h66;
  localparam logic [ByteW-1:0] ChLowN   = 8'h6E;
  localparam logic [ByteW-1:0] ChLowR   = 8'h72;
  localparam logic [ByteW-1:0] ChLowT   = 8'h74;
  localparam logic [ByteW-1:0] ChLowU   = 8'h75;
  localparam logic [ByteW-1:0] ChBs     = 8'h08;
  localparam logic [ByteW-1:0] ChFf     = 8'h0C;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChTab    = 8'h09;

  // utf-8 encoding constants
  localparam logic [CodeW-1:0] Max1Byte = 16'h007F;
  localparam logic [CodeW-1:0] Max2Byte = 16'h07FF;
  localparam logic [ByteW-1:0] Lead2    = 8'hC0;
  localparam logic [ByteW-1:0] Lead3    = 8'hE0;
  localparam logic [ByteW-1:0] ContByte = 8'h80;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NOLEAD  = 2'd0,
    ERR_ESCAPE  = 2'd1,
    ERR_UNICODE = 2'd2,
    ERR_NOTRAIL = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    MODE_SEEK = 3'd0,
    MODE_STR  = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX0 = 3'd3,
    MODE_HEX1 = 3'd4,
    MODE_HEX2 = 3'd5,
    MODE_HEX3 = 3'd6
  } mode_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    kind_e            kind;
    err_e             err;
  } res_t;

  // group of results caused by one input beat
  typedef struct packed {
    logic [CntW-1:0] cnt;
    res_t            r2;
    res_t            r1;
    res_t            r0;
  } grp_t;

  function automatic res_t mk_data(logic [ByteW-1:0] b);
    res_t r;
    r.data = b;
    r.kind = KIND_DATA;
    r.err  = ERR_NOLEAD;
    return r;
  endfunction

  function automatic res_t mk_end();
    res_t r;
    r.data = '0;
    r.kind = KIND_END;
    r.err  = ERR_NOLEAD;
    return r;
  endfunction

  function automatic res_t mk_err(err_e e);
    res_t r;
    r.data = '0;
    r.kind = KIND_ERR;
    r.err  = e;
    return r;
  endfunction

  // hex digit value, bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_val(logic [ByteW-1:0] c);
    logic [4:0] v;
    v = '0;
    if (c inside {[8'h30:8'h39]}) v = {1'b1, c[3:0]};
    else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) v = {1'b1, c[3:0] + 4'd9};
    return v;
  endfunction

  function automatic logic is_space(logic [ByteW-1:0] c);
    return (c == ChSpace) || (c inside {[8'h09:8'h0D]});
  endfunction

endpackage

[hdl/jsu_decode.sv]
// parser state (mode, collected code point) and the per-beat decode
// depends on jsu_pkg
module jsu_decode import jsu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             eoi_i,
  output grp_t             grp_o
);

  mode_e            mode_q, mode_d;
  logic [CodeW-1:0] cp_q, cp_d;
  logic [4:0]       hv;
  logic [CodeW-1:0] cp_full;
  grp_t             g;

  assign hv      = hex_val(byte_i);
  assign cp_full = {cp_q[CodeW-5:0], hv[3:0]};

  // decode one byte into next state and up to three results
  always_comb begin
    mode_d = mode_q;
    cp_d   = cp_q;
    g.cnt  = 2'd0;
    g.r0   = mk_end();
    g.r1   = mk_end();
    g.r2   = mk_end();
    case (mode_q)
      MODE_SEEK: begin
        if (byte_i == ChQuote) begin
          mode_d = MODE_STR;
          if (eoi_i) begin
            g.r0 = mk_err(ERR_NOTRAIL); g.cnt = 2'd1;
            mode_d = MODE_SEEK; cp_d = '0;
          end
        end else if (is_space(byte_i)) begin
          if (eoi_i) begin
            g.r0 = mk_err(ERR_NOLEAD); g.cnt = 2'd1; cp_d = '0;
          end
        end else begin
          g.r0 = mk_err(ERR_NOLEAD); g.cnt = 2'd1; cp_d = '0;
        end
      end
      MODE_STR: begin
        if (byte_i == ChQuote) begin
          g.r0 = mk_end(); g.cnt = 2'd1;
          mode_d = MODE_SEEK; cp_d = '0;
        end else if (byte_i == ChBslash) begin
          mode_d = MODE_ESC;
          if (eoi_i) begin
            g.r0 = mk_err(ERR_NOTRAIL); g.cnt = 2'd1;
            mode_d = MODE_SEEK; cp_d = '0;
          end
        end else begin
          g.r0 = mk_data(byte_i); g.cnt = 2'd1;
          if (eoi_i) begin
            g.r1 = mk_err(ERR_NOTRAIL); g.cnt = 2'd2;
            mode_d = MODE_SEEK; cp_d = '0;
          end
        end
      end
      MODE_ESC: begin
        logic             known;
        logic [ByteW-1:0] v;
        known = 1'b1;
        v     = byte_i;
        case (byte_i)
          ChBslash, ChQuote: v = byte_i;
          ChLowB: v = ChBs;
          ChLowF: v = ChFf;
          ChLowN: v = ChLf;
          ChLowR: v = ChCr;
          ChLowT: v = ChTab;
          default: known = 1'b0;
        endcase
        if (known) begin
          g.r0 = mk_data(v); g.cnt = 2'd1; mode_d = MODE_STR;
          if (eoi_i) begin
            g.r1 = mk_err(ERR_NOTRAIL); g.cnt = 2'd2;
            mode_d = MODE_SEEK; cp_d = '0;
          end
        end else if (byte_i == ChLowU) begin
          cp_d = '0; mode_d = MODE_HEX0;
          if (eoi_i) begin
            g.r0 = mk_err(ERR_UNICODE); g.cnt = 2'd1; mode_d = MODE_SEEK;
          end
        end else begin
          g.r0 = mk_err(ERR_ESCAPE); g.cnt = 2'd1;
          mode_d = MODE_SEEK; cp_d = '0;
        end
      end
      MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        if (!hv[4] || eoi_i) begin
          g.r0 = mk_err(ERR_UNICODE); g.cnt = 2'd1;
          mode_d = MODE_SEEK; cp_d = '0;
        end else if (mode_q == MODE_HEX3) begin
          // encode the collected code point as utf-8
          cp_d = '0; mode_d = MODE_STR;
          if (cp_full <= Max1Byte) begin
            g.r0 = mk_data(cp_full[ByteW-1:0]); g.cnt = 2'd1;
          end else if (cp_full <= Max2Byte) begin
            g.r0 = mk_data(Lead2 | {3'd0, cp_full[10:6]});
            g.r1 = mk_data(ContByte | {2'd0, cp_full[5:0]});
            g.cnt = 2'd2;
          end else begin
            g.r0 = mk_data(Lead3 | {4'd0, cp_full[15:12]});
            g.r1 = mk_data(ContByte | {2'd0, cp_full[11:6]});
            g.r2 = mk_data(ContByte | {2'd0, cp_full[5:0]});
            g.cnt = 2'd3;
          end
        end else begin
          cp_d   = cp_full;
          mode_d = mode_e'(mode_q + 3'd1);
        end
      end
      default: begin
        mode_d = MODE_SEEK; cp_d = '0;
      end
    endcase
  end

  assign grp_o = g;

  // parser state, updated when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SEEK;
      cp_q   <= '0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      cp_q   <= cp_d;
    end
  end

  // an error always returns the parser to seeking
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && g.cnt != 2'd0 && (g.r0.kind == KIND_ERR || g.r1.kind == KIND_ERR)
    |=> mode_q == MODE_SEEK && cp_q == '0)
    else $error("error result without return to seek");

endmodule

[hdl/jsu_out.sv]
// result register: holds one group of up to three results and sends them one beat each
// depends on jsu_pkg
module jsu_out import jsu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  grp_t             grp_i,
  output logic             can_load_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [ByteW-1:0] m_axis_tdata,  // out_byte
  output logic [UserW-1:0] m_axis_tuser,  // [1:0] kind, [3:2] error_code
  output logic             m_axis_tlast   // last
);

  grp_t            grp_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic            vld_q, vld_d;
  logic            fin;
  res_t            cur;

  // pick the current result of the group
  always_comb begin
    case (idx_q)
      2'd0:    cur = grp_q.r0;
      2'd1:    cur = grp_q.r1;
      default: cur = grp_q.r2;
    endcase
  end

  assign fin        = (idx_q == grp_q.cnt - 2'd1);
  assign can_load_o = !vld_q || (m_axis_tready && fin);

  // advance within the group or take a new one
  always_comb begin
    vld_d = vld_q;
    idx_d = idx_q;
    if (load_i) begin
      vld_d = (grp_i.cnt != 2'd0);
      idx_d = '0;
    end else if (vld_q && m_axis_tready) begin
      if (fin) vld_d = 1'b0;
      else     idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  // group payload
  always_ff @(posedge clk_i) begin
    if (load_i) grp_q <= grp_i;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = cur.data;
  assign m_axis_tuser  = {cur.err, cur.kind};
  assign m_axis_tlast  = fin;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> grp_q.cnt != 2'd0)
    else $error("empty group held as valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> idx_q < grp_q.cnt)
    else $error("result index beyond group");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && cur.kind == KIND_ERR |-> fin)
    else $error("error result not final in its group");

endmodule

[hdl/json_string_unescape_utf8_core.sv]
// top level of the json string unescaper with utf-8 output
// depends on jsu_pkg, jsu_decode, jsu_out
//
//  channel   dir  tdata        tuser                      tlast
//  s_axis    in   in_byte      -                          end_of_input
//  m_axis    out  out_byte     kind, error_code           last
//
// with m_axis ready, one input beat per cycle is taken while each byte gives
// at most one result; a closing \uXXXX digit (up to three beats) or a byte
// ending the buffer (up to two) sends one result beat per cycle while m_axis
// is ready, and the input register waits meanwhile.
// reset clears the parser to seeking and empties both registers.
// a stall on m_axis backs up into s_axis through the input register.
module json_string_unescape_utf8_core import jsu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [ByteW-1:0] s_axis_tdata,   // in_byte
  input  logic             s_axis_tlast,   // end_of_input
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [ByteW-1:0] m_axis_tdata,   // out_byte
  output logic [UserW-1:0] m_axis_tuser,   // [1:0] kind, [3:2] error_code
  output logic             m_axis_tlast    // last
);

  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic             can_load;
  logic             fire;
  grp_t             grp;

  assign fire          = in_vld_q && can_load;
  assign s_axis_tready = !in_vld_q || fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  jsu_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .eoi_i  (in_last_q),
    .grp_o  (grp)
  );

  jsu_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (fire),
    .grp_i         (grp),
    .can_load_o    (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
